FILE: rtl/rfdd_pkg.sv
// Shared types, constants and the control ROM for the range filter / door detector.
// Used by the top level and the port checker. No dependencies.

package rfdd_pkg;

  localparam int unsigned DIST_BITS = 13;
  localparam int unsigned REG_BITS  = 13;
  localparam int unsigned PC_W      = 4;

  // Door states
  localparam logic [1:0] DOOR_UNKNOWN = 2'd0;
  localparam logic [1:0] DOOR_OPEN    = 2'd1;
  localparam logic [1:0] DOOR_CLOSED  = 2'd2;

  // Register indexes (word address)
  localparam logic [1:0] REG_OPEN  = 2'd0;
  localparam logic [1:0] REG_CLOSE = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;

  // Microprogram step addresses
  localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] ST_ZACC  = 4'd1;
  localparam logic [PC_W-1:0] ST_ZDIV  = 4'd2;
  localparam logic [PC_W-1:0] ST_ZWAIT = 4'd3;
  localparam logic [PC_W-1:0] ST_DOOR  = 4'd4;
  localparam logic [PC_W-1:0] ST_WACC  = 4'd5;
  localparam logic [PC_W-1:0] ST_WDIV  = 4'd6;
  localparam logic [PC_W-1:0] ST_WWAIT = 4'd7;
  localparam logic [PC_W-1:0] ST_OWAIT = 4'd8;
  localparam logic [PC_W-1:0] ST_PUB   = 4'd9;

  typedef struct packed {
    logic [DIST_BITS-1:0] zone_a_distance;
    logic                 zone_a_valid;
    logic [DIST_BITS-1:0] zone_b_distance;
    logic                 zone_b_valid;
    logic [DIST_BITS-1:0] zone_c_distance;
    logic                 zone_c_valid;
    logic [DIST_BITS-1:0] zone_d_distance;
    logic                 zone_d_valid;
  } in_item_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] raw_distance;
    logic [DIST_BITS-1:0] filtered_distance;
    logic [1:0]           door_state;
    logic                 door_changed;
    logic                 publish;
  } out_item_t;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_ZONE,
    ACC_WIN
  } acc_e;

  // Jump condition: when true go to target, else fall through
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_NO_IN,
    JMP_ZONE_MORE,
    JMP_CNT_ZERO,
    JMP_DIV_BUSY,
    JMP_WIN_MORE,
    JMP_OUT_BUSY
  } jmp_e;

  typedef struct packed {
    acc_e            acc_op;
    logic            div_start;
    logic            div_win;
    logic            clr_raw;
    logic            ld_raw;
    logic            ld_filt;
    logic            door_upd;
    logic            out_load;
    jmp_e            jmp;
    logic [PC_W-1:0] tgt;
  } ctl_t;

  // Control ROM: one word per step
  function automatic ctl_t ctl_rom(logic [PC_W-1:0] pc);
    ctl_t w;
    w = '{acc_op: ACC_HOLD, div_start: 1'b0, div_win: 1'b0, clr_raw: 1'b0,
          ld_raw: 1'b0, ld_filt: 1'b0, door_upd: 1'b0, out_load: 1'b0,
          jmp: JMP_ALWAYS, tgt: ST_IDLE};
    unique case (pc)
      ST_IDLE: begin
        w.acc_op = ACC_CLR;
        w.jmp    = JMP_NO_IN;
        w.tgt    = ST_IDLE;
      end
      ST_ZACC: begin
        w.acc_op = ACC_ZONE;
        w.jmp    = JMP_ZONE_MORE;
        w.tgt    = ST_ZACC;
      end
      ST_ZDIV: begin
        w.div_start = 1'b1;
        w.clr_raw   = 1'b1;
        w.jmp       = JMP_CNT_ZERO;
        w.tgt       = ST_DOOR;
      end
      ST_ZWAIT: begin
        w.ld_raw = 1'b1;
        w.jmp    = JMP_DIV_BUSY;
        w.tgt    = ST_ZWAIT;
      end
      ST_DOOR: begin
        w.acc_op   = ACC_CLR;
        w.door_upd = 1'b1;
        w.jmp      = JMP_NEXT;
      end
      ST_WACC: begin
        w.acc_op = ACC_WIN;
        w.jmp    = JMP_WIN_MORE;
        w.tgt    = ST_WACC;
      end
      ST_WDIV: begin
        w.div_start = 1'b1;
        w.div_win   = 1'b1;
        w.jmp       = JMP_NEXT;
      end
      ST_WWAIT: begin
        w.ld_filt = 1'b1;
        w.jmp     = JMP_DIV_BUSY;
        w.tgt     = ST_WWAIT;
      end
      ST_OWAIT: begin
        w.jmp = JMP_OUT_BUSY;
        w.tgt = ST_OWAIT;
      end
      ST_PUB: begin
        w.out_load = 1'b1;
        w.jmp      = JMP_ALWAYS;
        w.tgt      = ST_IDLE;
      end
      default: begin
        w.jmp = JMP_ALWAYS;
        w.tgt = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/rfdd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by the range filter top level for both means.

module rfdd_div #(
  parameter int unsigned DVD_W = 16,
  parameter int unsigned DVS_W = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W:0]   trial;
  logic             qbit;

  // One restoring step
  always_comb begin
    trial  = {rem_q, dvd_q[DVD_W-1]};
    qbit   = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = dvd_q;

endmodule

FILE: rtl/range_filter_door_detector_unit.sv
// Range filter and door detector. Each frame uses the shared divider, one quotient bit a cycle,
// once for the zone mean (skipped when no zone is valid) and once for the window mean, with
// the window entries summed in between. One frame at a time; the next frame is taken once the
// previous result is in the output register. Reset clears control state and loads thresholds
// 500/800 and step 50; window contents are not cleared (fill count hides them). Depends on
// rfdd_pkg and rfdd_div.

module range_filter_door_detector_unit #(
  parameter int unsigned WINDOW_LEN = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rfdd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rfdd_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import rfdd_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned ACC_W = DIST_BITS + ((CNT_W > 2) ? CNT_W : 2);
  localparam int unsigned DIV_W = (CNT_W > 3) ? CNT_W : 3;

  // Configuration registers
  logic [REG_BITS-1:0] open_thr_q, close_thr_q, step_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_thr_q  <= REG_BITS'(500);
      close_thr_q <= REG_BITS'(800);
      step_q      <= REG_BITS'(50);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_OPEN:  open_thr_q  <= pwdata[REG_BITS-1:0];
        REG_CLOSE: close_thr_q <= pwdata[REG_BITS-1:0];
        REG_STEP:  step_q      <= pwdata[REG_BITS-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_OPEN:  prdata = 32'(open_thr_q);
      REG_CLOSE: prdata = 32'(close_thr_q);
      REG_STEP:  prdata = 32'(step_q);
      default:   prdata = '0;
    endcase
  end

  // Sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ctl_t            ctl;
  logic            jmp_take;
  logic            in_acc;
  logic            out_busy;

  // Datapath state
  in_item_t             frame_q;
  logic [ACC_W-1:0]     acc_q;
  logic [1:0]           zidx_q;
  logic [2:0]           zcnt_q;
  logic [IDX_W-1:0]     widx_q, wr_idx_q;
  logic [CNT_W-1:0]     fill_q;
  logic [DIST_BITS-1:0] win_q [WINDOW_LEN];
  logic [DIST_BITS-1:0] raw_q, last_raw_q, filt_q, last_rep_q;
  logic [1:0]           door_q, door_nxt;
  logic                 changed_q, has_rep_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  // Divider hookup
  logic             div_go, div_busy;
  logic [ACC_W-1:0] div_q;
  logic [DIV_W-1:0] div_dvs;

  logic [DIST_BITS-1:0] zone_dist;
  logic                 zone_vld;
  logic [DIST_BITS-1:0] delta;
  logic                 pub;

  assign ctl      = ctl_rom(pc_q);
  assign in_ready_o = (pc_q == ST_IDLE);
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    unique case (ctl.jmp)
      JMP_NEXT:      jmp_take = 1'b0;
      JMP_ALWAYS:    jmp_take = 1'b1;
      JMP_NO_IN:     jmp_take = !in_valid_i;
      JMP_ZONE_MORE: jmp_take = (zidx_q != 2'd3);
      JMP_CNT_ZERO:  jmp_take = (zcnt_q == 3'd0);
      JMP_DIV_BUSY:  jmp_take = div_busy;
      JMP_WIN_MORE:  jmp_take = ((CNT_W'(widx_q) + 1'b1) != fill_q);
      JMP_OUT_BUSY:  jmp_take = out_busy;
      default:       jmp_take = 1'b0;
    endcase
    pc_d = jmp_take ? ctl.tgt : (pc_q + 1'b1);
  end

  // Zone select for the accumulate loop
  always_comb begin
    unique case (zidx_q)
      2'd0: begin zone_dist = frame_q.zone_a_distance; zone_vld = frame_q.zone_a_valid; end
      2'd1: begin zone_dist = frame_q.zone_b_distance; zone_vld = frame_q.zone_b_valid; end
      2'd2: begin zone_dist = frame_q.zone_c_distance; zone_vld = frame_q.zone_c_valid; end
      default: begin
        zone_dist = frame_q.zone_d_distance;
        zone_vld  = frame_q.zone_d_valid;
      end
    endcase
  end

  // Door hysteresis
  always_comb begin
    unique case (door_q)
      DOOR_OPEN: door_nxt = (raw_q > close_thr_q) ? DOOR_CLOSED : DOOR_OPEN;
      default:   door_nxt = (raw_q < open_thr_q) ? DOOR_OPEN : DOOR_CLOSED;
    endcase
  end

  // Publish decision
  assign delta = (filt_q > last_rep_q) ? (filt_q - last_rep_q) : (last_rep_q - filt_q);
  assign pub   = !has_rep_q || (delta >= step_q);

  // Divider: skip the zone mean when no zone has a target
  assign div_go  = ctl.div_start && (ctl.div_win || (zcnt_q != 3'd0));
  assign div_dvs = ctl.div_win ? DIV_W'(fill_q) : DIV_W'(zcnt_q);

  rfdd_div #(
    .DVD_W (ACC_W),
    .DVS_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (acc_q),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ST_IDLE;
      wr_idx_q    <= '0;
      fill_q      <= '0;
      door_q      <= DOOR_UNKNOWN;
      last_raw_q  <= '0;
      last_rep_q  <= '0;
      has_rep_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (ctl.door_upd) begin
        if (raw_q != last_raw_q) begin
          last_raw_q <= raw_q;
          door_q     <= door_nxt;
        end
        wr_idx_q <= (wr_idx_q == IDX_W'(WINDOW_LEN - 1)) ? '0 : (wr_idx_q + 1'b1);
        if (fill_q != CNT_W'(WINDOW_LEN)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (ctl.out_load) begin
        out_valid_q <= 1'b1;
        if (pub) begin
          last_rep_q <= filt_q;
          has_rep_q  <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frame_q <= in_data_i;
    end
    unique case (ctl.acc_op)
      ACC_CLR: begin
        acc_q  <= '0;
        zidx_q <= '0;
        zcnt_q <= '0;
        widx_q <= '0;
      end
      ACC_ZONE: begin
        if (zone_vld) begin
          acc_q  <= acc_q + ACC_W'(zone_dist);
          zcnt_q <= zcnt_q + 1'b1;
        end
        zidx_q <= zidx_q + 1'b1;
      end
      ACC_WIN: begin
        acc_q  <= acc_q + ACC_W'(win_q[widx_q]);
        widx_q <= widx_q + 1'b1;
      end
      default: ;
    endcase
    if (ctl.clr_raw) begin
      raw_q <= '0;
    end else if (ctl.ld_raw && !div_busy) begin
      raw_q <= div_q[DIST_BITS-1:0];
    end
    if (ctl.ld_filt && !div_busy) begin
      filt_q <= div_q[DIST_BITS-1:0];
    end
    if (ctl.door_upd) begin
      win_q[wr_idx_q] <= raw_q;
      changed_q       <= (raw_q != last_raw_q) && (door_nxt != door_q);
    end
    if (ctl.out_load) begin
      out_q.raw_distance      <= raw_q;
      out_q.filtered_distance <= filt_q;
      out_q.door_state        <= door_q;
      out_q.door_changed      <= changed_q;
      out_q.publish           <= pub;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/rfdd_checker.sv
// Port-level checks for the range filter / door detector, bound to the top level.
// Depends on rfdd_pkg for the result type and door codes.

module rfdd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rfdd_pkg::out_item_t out_data_o
);

  import rfdd_pkg::*;

  // Tracks whether the first result since reset is still pending
  logic first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      first_q <= 1'b0;
    end
  end

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // One frame in flight: ready drops after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second frame accepted while one is in flight");

  // A change of door state never lands on unknown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.door_changed |-> out_data_o.door_state != DOOR_UNKNOWN)
    else $error("door changed to unknown");

  // The first result after reset is always published
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_q |-> out_data_o.publish)
    else $error("first result not published");

endmodule

bind range_filter_door_detector_unit rfdd_checker u_rfdd_checker (.*);
